// ===== rtl/bps_pkg.sv =====
// package: shared types and constants for the button power supervisor
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    localparam int unsigned DEB_W    = 3;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned CHARGE_W = 8;
    localparam int unsigned IDLE_W   = 18;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 18;

    localparam logic [DEB_W-1:0]    SAME_MAX   = '1;
    localparam logic [HOLD_W-1:0]   HOLD_MAX   = '1;
    localparam logic [CHARGE_W-1:0] CHARGE_MAX = '1;
    localparam logic [IDLE_W-1:0]   IDLE_MAX   = '1;

    localparam logic [DEB_W-1:0]    DEB_RST       = 3'd3;
    localparam logic [HOLD_W-1:0]   HOLD_RST      = 16'd900;
    localparam logic [CHARGE_W-1:0] CHARGE_RST    = 8'd21;
    localparam logic [IDLE_W-1:0]   IDLE_STOP_RST = 18'd66000;
    localparam logic [IDLE_W-1:0]   IDLE_OFF_RST  = 18'd96000;

    typedef enum logic [1:0] {
        BTN_UP      = 2'd0,
        BTN_PRESSED = 2'd1,
        BTN_UNSEEN  = 2'd2
    } btn_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } ev_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_LONG_HOLD = 3'd1,
        REG_CHARGE    = 3'd2,
        REG_IDLE_STOP = 3'd3,
        REG_IDLE_OFF  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [DEB_W-1:0]    debounce_ticks;
        logic [HOLD_W-1:0]   long_hold_ticks;
        logic [CHARGE_W-1:0] charge_ticks;
        logic [IDLE_W-1:0]   idle_stop_ticks;
        logic [IDLE_W-1:0]   idle_off_ticks;
    } cfg_t;

    typedef struct packed {
        logic button_level;
        logic charger_pin;
        logic runnable;
        logic idle_clear;
    } req_t;

    typedef struct packed {
        ev_t  button_event;
        logic motor_run;
        logic power_off;
        logic link_safe;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/button_power_supervisor.sv =====
// top level: config registers, supervisor core and two-entry output buffer
// One request per 10 ms tick, one result per request. A request can be taken
// every clock cycle while in_stall is low; its result is registered into the
// output register, or into the skid register behind it while a result waits
// there, so one more request gets in; in_stall rises only when both are full.
// All tick work (debounce, hold, charge and idle counters, motor and power-off
// flags) is one combinational pass from the inputs and the state registers.
// Config writes are always ready and are meant to happen while no result is
// pending. Power off stays latched until reset.
`timescale 1ns / 1ps
`default_nettype none

module button_power_supervisor
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           button_level,
    input  wire logic                           charger_pin,
    input  wire logic                           runnable,
    input  wire logic                           idle_clear,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          button_event,
    output logic                                motor_run,
    output logic                                power_off,
    output logic                                link_safe,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bps_pkg::*;

    cfg_t cfg_reg;
    req_t req;
    rsp_t rsp;
    rsp_t main_reg, main_next;
    rsp_t skid_reg, skid_next;
    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic accept;
    logic pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid & ~skid_valid_reg;
    assign pop       = main_valid_reg & ~out_stall;

    assign req.button_level = button_level;
    assign req.charger_pin  = charger_pin;
    assign req.runnable     = runnable;
    assign req.idle_clear   = idle_clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks  <= DEB_RST;
            cfg_reg.long_hold_ticks <= HOLD_RST;
            cfg_reg.charge_ticks    <= CHARGE_RST;
            cfg_reg.idle_stop_ticks <= IDLE_STOP_RST;
            cfg_reg.idle_off_ticks  <= IDLE_OFF_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE:  cfg_reg.debounce_ticks  <= cfg_data[DEB_W-1:0];
                REG_LONG_HOLD: cfg_reg.long_hold_ticks <= cfg_data[HOLD_W-1:0];
                REG_CHARGE:    cfg_reg.charge_ticks    <= cfg_data[CHARGE_W-1:0];
                REG_IDLE_STOP: cfg_reg.idle_stop_ticks <= cfg_data[IDLE_W-1:0];
                REG_IDLE_OFF:  cfg_reg.idle_off_ticks  <= cfg_data[IDLE_W-1:0];
                default:       ;
            endcase
        end
    end

    bps_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cfg    (cfg_reg),
        .req    (req),
        .rsp    (rsp)
    );

    // output register with skid
    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                main_next = rsp;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!main_valid_reg)
            begin
                main_next       = rsp;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = rsp;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = main_valid_reg;
    assign button_event = main_reg.button_event;
    assign motor_run    = main_reg.motor_run;
    assign power_off    = main_reg.power_off;
    assign link_safe    = main_reg.link_safe;

endmodule

`default_nettype wire

// ===== rtl/bps_core.sv =====
// per-tick supervisor state and next-state logic
`timescale 1ns / 1ps
`default_nettype none

module bps_core
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire bps_pkg::cfg_t cfg,
    input  wire bps_pkg::req_t req,
    output bps_pkg::rsp_t      rsp
);
    import bps_pkg::*;

    btn_t                last_sample_reg, last_sample_next;
    logic [DEB_W-1:0]    same_count_reg, same_count_next;
    btn_t                stable_state_reg, stable_state_next;
    logic                press_seen_reg, press_seen_next;
    logic                running_reg, running_next;
    logic                start_enabled_reg, start_enabled_next;
    logic [HOLD_W-1:0]   hold_count_reg, hold_count_next;
    logic [CHARGE_W-1:0] charge_count_reg, charge_count_next;
    logic [IDLE_W-1:0]   idle_count_reg, idle_count_next;
    logic                off_latched_reg, off_latched_next;

    btn_t             cur;
    ev_t              ev;
    logic [DEB_W-1:0] same_inc;
    logic [IDLE_W-1:0] idle_base;

    always_comb
    begin
        cur                = req.button_level ? BTN_PRESSED : BTN_UP;
        ev                 = EV_NONE;
        last_sample_next   = last_sample_reg;
        same_count_next    = same_count_reg;
        stable_state_next  = stable_state_reg;
        press_seen_next    = press_seen_reg;
        running_next       = running_reg;
        start_enabled_next = start_enabled_reg;
        hold_count_next    = hold_count_reg;
        charge_count_next  = charge_count_reg;
        off_latched_next   = off_latched_reg;
        same_inc           = (same_count_reg != SAME_MAX) ? same_count_reg + 1'b1
                                                          : same_count_reg;
        idle_base          = req.idle_clear ? '0 : idle_count_reg;

        // debounce
        if (cur != last_sample_reg)
        begin
            last_sample_next = cur;
            same_count_next  = '0;
        end
        else
        begin
            same_count_next = same_inc;
            if (same_inc == cfg.debounce_ticks && last_sample_reg != stable_state_reg)
            begin
                if (stable_state_reg == BTN_UP && last_sample_reg == BTN_PRESSED)
                begin
                    ev              = EV_PRESS;
                    press_seen_next = 1'b1;
                end
                else if (stable_state_reg == BTN_PRESSED && last_sample_reg == BTN_UP)
                begin
                    if (press_seen_reg)
                        ev = EV_RELEASE;
                end
                stable_state_next = last_sample_reg;
            end
        end

        // events and hold
        if (ev != EV_NONE)
        begin
            idle_base = '0;
            if (ev == EV_PRESS && running_reg)
            begin
                running_next       = 1'b0;
                start_enabled_next = 1'b0;
            end
            else if (ev == EV_RELEASE && !running_reg)
            begin
                if (!start_enabled_reg)
                    start_enabled_next = 1'b1;
                else if (req.runnable)
                    running_next = 1'b1;
            end
            hold_count_next = '0;
        end
        else if (stable_state_next == BTN_UP)
        begin
            hold_count_next = '0;
        end
        else
        begin
            if (hold_count_reg != HOLD_MAX)
                hold_count_next = hold_count_reg + 1'b1;
            if (hold_count_next >= cfg.long_hold_ticks)
                off_latched_next = 1'b1;
        end

        // charging, pin low means charging
        if (!req.charger_pin)
        begin
            if (charge_count_reg != CHARGE_MAX)
                charge_count_next = charge_count_reg + 1'b1;
            if (charge_count_next >= cfg.charge_ticks)
            begin
                running_next     = 1'b0;
                off_latched_next = 1'b1;
            end
        end
        else
        begin
            charge_count_next = '0;
        end

        // idle timeout
        idle_count_next = (idle_base != IDLE_MAX) ? idle_base + 1'b1 : idle_base;
        if (idle_count_next >= cfg.idle_stop_ticks)
            running_next = 1'b0;
        if (idle_count_next >= cfg.idle_off_ticks)
            off_latched_next = 1'b1;
    end

    always_comb
    begin
        rsp.button_event = ev;
        rsp.motor_run    = running_next & ~off_latched_next;
        rsp.power_off    = off_latched_next;
        rsp.link_safe    = ~req.button_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg   <= BTN_UNSEEN;
            same_count_reg    <= '0;
            stable_state_reg  <= BTN_UNSEEN;
            press_seen_reg    <= 1'b0;
            running_reg       <= 1'b0;
            start_enabled_reg <= 1'b1;
            hold_count_reg    <= '0;
            charge_count_reg  <= '0;
            idle_count_reg    <= '0;
            off_latched_reg   <= 1'b0;
        end
        else if (accept)
        begin
            last_sample_reg   <= last_sample_next;
            same_count_reg    <= same_count_next;
            stable_state_reg  <= stable_state_next;
            press_seen_reg    <= press_seen_next;
            running_reg       <= running_next;
            start_enabled_reg <= start_enabled_next;
            hold_count_reg    <= hold_count_next;
            charge_count_reg  <= charge_count_next;
            idle_count_reg    <= idle_count_next;
            off_latched_reg   <= off_latched_next;
        end
    end

endmodule

`default_nettype wire
